// File: hdl/seq_pkg.sv
// ---------------------------------------------------------------------------
// seq_pkg: shared types and constants of the sorted event queue
// Item layout widths, command codes and the controller/datapath interface.
// ---------------------------------------------------------------------------
package seq_pkg;

   // item field widths
   localparam int FIELD_KIND_W = 2;
   localparam int FIELD_TIME_W = 32;
   localparam int FIELD_FILL_W = 5;

   // stream data widths, padded to whole bytes
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // operation codes carried on req_tuser
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic capture;    // latch the incoming item
      logic execute;    // perform the op and load the result register
      logic shift_in;   // insert the pending entry
      logic shift_out;  // remove the head entry
      logic ok;         // result status
   } ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic pend_pop;   // pending item is a pop
      logic full;
      logic empty;
   } status_type;

endpackage

// File: hdl/seq_ctrl.sv
// ---------------------------------------------------------------------------
// seq_ctrl: sequencing controller of the sorted event queue
// Takes one item, decides push/pop/refuse, and owns the result valid flag.
// ---------------------------------------------------------------------------
module seq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  seq_pkg::status_type status,
   output seq_pkg::ctrl_type  ctrl
);
   import seq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   // result register can take a new value this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      req_tready     = 1'b0;
      ctrl           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               ctrl.execute   = 1'b1;
               ctrl.shift_in  = !status.pend_pop && !status.full;
               ctrl.shift_out = status.pend_pop && !status.empty;
               ctrl.ok        = ctrl.shift_in || ctrl.shift_out;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: hdl/seq_datapath.sv
// ---------------------------------------------------------------------------
// seq_datapath: shift-register cells of the sorted event queue
// Every cell compares its time with the new entry in parallel; push shifts
// the later cells up by one, pop shifts all cells toward the head.
// ---------------------------------------------------------------------------
module seq_datapath #(
   parameter int CAPACITY  = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_cmd,
   input  logic [seq_pkg::FIELD_KIND_W-1:0]     req_kind,
   input  logic [seq_pkg::FIELD_TIME_W-1:0]     req_time,
   input  seq_pkg::ctrl_type                    ctrl,
   output seq_pkg::status_type                  status,
   output logic                                 rsp_ok,
   output logic [seq_pkg::FIELD_KIND_W-1:0]     rsp_kind,
   output logic [seq_pkg::FIELD_TIME_W-1:0]     rsp_time,
   output logic [seq_pkg::FIELD_FILL_W-1:0]     rsp_fill
);
   import seq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // entry cells, slot 0 is the head
   logic [TIME_BITS-1:0]    time_ff [CAPACITY];
   logic [TIME_BITS-1:0]    time_in [CAPACITY];
   logic [FIELD_KIND_W-1:0] kind_ff [CAPACITY];
   logic [FIELD_KIND_W-1:0] kind_in [CAPACITY];
   logic [CAPACITY-1:0]     later;
   logic [CNT_W-1:0]        count_ff, count_in;

   // pending item
   logic                    pend_pop_ff;
   logic [FIELD_KIND_W-1:0] pend_kind_ff;
   logic [TIME_BITS-1:0]    pend_time_ff;

   // result register
   logic                    rsp_ok_ff;
   logic [FIELD_KIND_W-1:0] rsp_kind_ff;
   logic [FIELD_TIME_W-1:0] rsp_time_ff;
   logic [FIELD_FILL_W-1:0] rsp_fill_ff;

   assign status.pend_pop = pend_pop_ff;
   assign status.full     = (count_ff == CNT_W'(CAPACITY));
   assign status.empty    = (count_ff == '0);

   // per-cell compare: valid entry with a strictly later time
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         later[i] = (CNT_W'(i) < count_ff) && (time_ff[i] > pend_time_ff);
      end
   end

   // cell next values
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         time_in[i] = time_ff[i];
         kind_in[i] = kind_ff[i];
         if (ctrl.shift_in) begin
            if (i > 0 && later[(i > 0) ? i - 1 : 0]) begin
               time_in[i] = time_ff[(i > 0) ? i - 1 : 0];
               kind_in[i] = kind_ff[(i > 0) ? i - 1 : 0];
            end else if (later[i] || CNT_W'(i) == count_ff) begin
               time_in[i] = pend_time_ff;
               kind_in[i] = pend_kind_ff;
            end
         end else if (ctrl.shift_out && i < CAPACITY - 1) begin
            time_in[i] = time_ff[(i < CAPACITY - 1) ? i + 1 : i];
            kind_in[i] = kind_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (ctrl.shift_in) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.shift_out) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // cells and payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         time_ff[i] <= time_in[i];
         kind_ff[i] <= kind_in[i];
      end
      if (ctrl.capture) begin
         pend_pop_ff  <= (req_cmd == CMD_POP);
         pend_kind_ff <= req_kind;
         pend_time_ff <= TIME_BITS'(req_time);
      end
      if (ctrl.execute) begin
         rsp_ok_ff   <= ctrl.ok;
         rsp_kind_ff <= ctrl.shift_out ? kind_ff[0] : '0;
         rsp_time_ff <= ctrl.shift_out ? FIELD_TIME_W'(time_ff[0]) : '0;
         rsp_fill_ff <= FIELD_FILL_W'(count_in);
      end
   end

   assign rsp_ok   = rsp_ok_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_time = rsp_time_ff;
   assign rsp_fill = rsp_fill_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift_in |=> count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
      else $error("push did not add one entry");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift_out |=> count_ff == CNT_W'($past(count_ff) - CNT_W'(1)))
      else $error("pop did not remove one entry");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(2) |-> time_ff[0] <= time_ff[1])
      else $error("head entries out of order");

endmodule

// File: hdl/sorted_event_queue_core.sv
// Accepted items are held as pending, then moved to the result register once it is free.
// The capture/execute controller handles one item at a time; req_tready is low until done.
// A push or pop moves all cells at once, so handling does not depend on fill.
// Reset (synchronous, active high) empties the queue and drops rsp_tvalid.
// No clearing pass: entry storage is qualified by the entry count.
// ---------------------------------------------------------------------------
// sorted_event_queue_core: bounded sorted future-event queue
// Push inserts after every entry with time <= new time; pop returns the head.
// ---------------------------------------------------------------------------
module sorted_event_queue_core #(
   parameter int CAPACITY  = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [seq_pkg::REQ_TDATA_W-1:0]  req_tdata,  // event_kind[1:0], event_time[33:2]
   input  logic                             req_tuser,  // cmd (0 push, 1 pop)
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [seq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // out_kind[1:0], out_time[33:2],
                                                        // fill_count[38:34]
   output logic                             rsp_tuser   // ok
);
   import seq_pkg::*;

   ctrl_type                ctrl;
   status_type              status;
   logic                    rsp_ok;
   logic [FIELD_KIND_W-1:0] rsp_kind;
   logic [FIELD_TIME_W-1:0] rsp_time;
   logic [FIELD_FILL_W-1:0] rsp_fill;

   seq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   seq_datapath #(
      .CAPACITY  (CAPACITY),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_cmd  (req_tuser),
      .req_kind (req_tdata[FIELD_KIND_W-1:0]),
      .req_time (req_tdata[FIELD_KIND_W +: FIELD_TIME_W]),
      .ctrl     (ctrl),
      .status   (status),
      .rsp_ok   (rsp_ok),
      .rsp_kind (rsp_kind),
      .rsp_time (rsp_time),
      .rsp_fill (rsp_fill)
   );

   // pack result item, zero padded to whole bytes
   assign rsp_tdata = RSP_TDATA_W'({rsp_fill, rsp_time, rsp_kind});
   assign rsp_tuser = rsp_ok;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for sorted_event_queue_core
// Streams push and pop items into the queue and checks every result against
// a behavioral copy of the future-event list. The run starts with directed
// corner items and then sends random bursts that swing the fill level
// between empty and full. Both sides of the stream idle at random.
// ---------------------------------------------------------------------------

module testbench;
   import seq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 2000;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 500;
   localparam int PAUSE_AT     = 1200;
   localparam int STALL_LIMIT  = 4000;

   // one predicted result item
   typedef struct {
      logic       ok;
      logic [1:0] kind;
      logic [31:0] stamp;
      logic [4:0] fill;
   } outcome_type;

   // behavioral future-event list plus the results it still owes
   class scoreboard_type;
      logic [31:0] held_time[QUEUE_DEPTH];
      logic [1:0]  held_kind[QUEUE_DEPTH];
      int          held_count;
      outcome_type due_outcomes[$];
      int          mismatches;

      function new();
         held_count = 0;
         mismatches = 0;
      endfunction

      function int pending();
         return due_outcomes.size();
      endfunction

      // apply one accepted item and queue the result it must produce
      function void apply_op(logic cmd, logic [1:0] kind, logic [31:0] stamp);
         outcome_type o;
         int pos;
         int i;
         o = '{ok: 1'b0, kind: 2'd0, stamp: 32'd0, fill: 5'd0};
         if (cmd == CMD_PUSH) begin
            if (held_count < QUEUE_DEPTH) begin
               // insert behind every entry with time <= new time
               pos = 0;
               while (pos < held_count && held_time[pos] <= stamp)
                  pos++;
               for (i = held_count; i > pos; i--) begin
                  held_time[i] = held_time[i-1];
                  held_kind[i] = held_kind[i-1];
               end
               held_time[pos] = stamp;
               held_kind[pos] = kind;
               held_count++;
               o.ok = 1'b1;
            end
         end else begin
            if (held_count > 0) begin
               o.kind  = held_kind[0];
               o.stamp = held_time[0];
               for (i = 1; i < held_count; i++) begin
                  held_time[i-1] = held_time[i];
                  held_kind[i-1] = held_kind[i];
               end
               held_count--;
               o.ok = 1'b1;
            end
         end
         o.fill = 5'(held_count);
         due_outcomes.push_back(o);
      endfunction

      // compare one accepted result with the oldest prediction
      function void check_outcome(logic ok, logic [1:0] kind, logic [31:0] stamp,
                                  logic [4:0] fill);
         outcome_type e;
         if (due_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with none due: ok=%0b kind=%0d time=%h fill=%0d",
                        $realtime, ok, kind, stamp, fill);
            return;
         end
         e = due_outcomes.pop_front();
         if (ok !== e.ok || kind !== e.kind || stamp !== e.stamp || fill !== e.fill) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: mismatch exp ok=%0b kind=%0d time=%h fill=%0d,",
                         " got ok=%0b kind=%0d time=%h fill=%0d"},
                        $realtime, e.ok, e.kind, e.stamp, e.fill, ok, kind, stamp, fill);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = CMD_PUSH;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   scoreboard_type board = new();

   bit send_idle = 1'b1;
   bit rsp_idle  = 1'b1;
   int idle_cycles = 0;

   sorted_event_queue_core #(
      .CAPACITY  (QUEUE_DEPTH),
      .TIME_BITS (32)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // event_kind[1:0], event_time[33:2]
      .req_tuser  (req_tuser),   // cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // out_kind[1:0], out_time[33:2], fill_count[38:34]
      .rsp_tuser  (rsp_tuser)    // ok
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // note accepted items and check accepted results at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.apply_op(req_tuser, req_tdata[1:0], req_tdata[33:2]);
         if (rsp_tvalid && rsp_tready)
            board.check_outcome(rsp_tuser, rsp_tdata[1:0], rsp_tdata[33:2],
                                rsp_tdata[38:34]);
      end
   end

   // watchdog: cycles in a row with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one item and hold it until the queue takes it
   task automatic send_item(input logic cmd, input logic [1:0] kind,
                            input logic [31:0] stamp);
      int gap;
      logic [REQ_TDATA_W-1:0] word;
      gap = send_idle ? $urandom_range(16) : 0;
      word = '0;
      word[1:0]  = kind;
      word[33:2] = stamp;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering until every owed result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // result side: random stalls, one long hold-off
   initial begin
      int gap;
      int seen;
      bit held;
      seen = 0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (seen == HOLD_AT && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = rsp_idle ? $urandom_range(16) : 0;
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen++;
         if (seen % 100 == 0)
            rsp_idle = ($urandom_range(3) != 0);
      end
   end

   // stimulus
   initial begin
      int push_pct;
      logic cmd;
      logic [1:0] kind;
      logic [31:0] stamp;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, ties, time extremes, every tag, fill to full
      send_item(CMD_POP,  2'd3, 32'hFFFF_FFFF);
      send_item(CMD_PUSH, 2'd0, 32'd100);
      send_item(CMD_PUSH, 2'd1, 32'd100);
      send_item(CMD_PUSH, 2'd2, 32'd100);
      send_item(CMD_PUSH, 2'd3, 32'd0);
      send_item(CMD_PUSH, 2'd0, 32'hFFFF_FFFF);
      send_item(CMD_PUSH, 2'd1, 32'hFFFF_FFFF);
      send_item(CMD_PUSH, 2'd2, 32'd50);
      send_item(CMD_PUSH, 2'd3, 32'd0);
      send_item(CMD_PUSH, 2'd0, 32'h7FFF_FFFF);
      send_item(CMD_PUSH, 2'd1, 32'h8000_0000);
      send_item(CMD_PUSH, 2'd2, 32'hAAAA_AAAA);
      send_item(CMD_PUSH, 2'd3, 32'h5555_5555);
      send_item(CMD_PUSH, 2'd0, 32'd1);
      send_item(CMD_PUSH, 2'd1, 32'hFFFF_FFFE);
      send_item(CMD_PUSH, 2'd2, 32'd100);
      send_item(CMD_PUSH, 2'd3, 32'h1234_5678);
      // queue is full now: this push is refused
      send_item(CMD_PUSH, 2'd3, 32'd0);
      repeat (6) send_item(CMD_POP, 2'd2, 32'hDEAD_BEEF);

      // random bursts with a drifting push share
      push_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(3))
               0: push_pct = 20;
               1: push_pct = 50;
               2: push_pct = 80;
               default: push_pct = 95;
            endcase
         end
         if (n % 100 == 0)
            send_idle = ($urandom_range(3) != 0);
         if (n == PAUSE_AT)
            wait_drained();
         cmd  = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
         kind = 2'($urandom_range(3));
         case ($urandom_range(3))
            0: stamp = 32'($urandom_range(15));         // dense ties
            1: stamp = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: stamp = $urandom;
         endcase
         send_item(cmd, kind, stamp);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
hdl/seq_pkg.sv
hdl/seq_ctrl.sv
hdl/seq_datapath.sv
hdl/sorted_event_queue_core.sv
tb/testbench.sv
